// ----- rtl/lslf_pkg.sv -----
// Shared constants, codes and types of the least-squares line fit block.
package lslf_pkg;

    // Input sample format and set size
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SAMPLES = 4096;
    localparam int FIELD_W     = 16;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // Running sums, sized for a full set
    localparam int SUM_W = 29;
    localparam int SXY_W = 45;
    localparam int SXX_W = 44;

    // Shared multiplier and accumulator
    localparam int MUL_W     = 33;
    localparam int ACC_W     = 64;
    localparam int ACC_SPLIT = 24;

    // Divider and result format
    localparam int DEN_W     = 55;
    localparam int DVD_W     = 72;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam int FRAC_W    = 16;
    localparam int Q_W       = 32;
    localparam int INT_SHIFT = 8;
    localparam int DMIN_W    = 40;

    localparam logic [DMIN_W-1:0]       DMIN_RESET = DMIN_W'(1);
    localparam logic signed [MUL_W-1:0] Q16_ONE    = MUL_W'(1) <<< FRAC_W;
    localparam logic signed [Q_W-1:0]   Q_MAX      = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0]   Q_MIN      = {1'b1, {(Q_W-1){1'b0}}};

    // Which running sum a product feeds
    typedef enum logic [1:0] {
        SUM_NONE = 2'd0,
        SUM_XY   = 2'd1,
        SUM_XX   = 2'd2
    } mac_sum_t;

    // What the accumulator does with a product
    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } acc_op_t;

    typedef enum logic [1:0] {
        FIT_OK         = 2'd0,
        FIT_DEGENERATE = 2'd1,
        FIT_OVERFLOW   = 2'd2
    } fit_status_t;

    typedef struct packed {
        mac_sum_t sum;
        acc_op_t  op;
        logic     shift;
    } mac_cmd_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
        logic           q_high;
    } div_rsp_t;

endpackage

// ----- rtl/lslf_point_if.sv -----
// Sample channel: one (x, y) point per transfer with a last-point flag.
interface lslf_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lslf_pkg::FIELD_W-1:0]  x_sample;
    logic signed [lslf_pkg::FIELD_W-1:0]  y_sample;
    logic                                 last_sample;

    modport source (output valid, output x_sample, output y_sample, output last_sample,
                    input ready);
    modport sink   (input valid, input x_sample, input y_sample, input last_sample,
                    output ready);
endinterface

// ----- rtl/lslf_fit_if.sv -----
// Result channel: slope, intercept and status of one fitted set per transfer.
interface lslf_fit_if;
    logic                             valid;
    logic                             ready;
    logic signed [lslf_pkg::Q_W-1:0]  slope;
    logic signed [lslf_pkg::Q_W-1:0]  intercept;
    logic [1:0]                       fit_status;

    modport source (output valid, output slope, output intercept, output fit_status,
                    input ready);
    modport sink   (input valid, input slope, input intercept, input fit_status,
                    output ready);
endinterface

// ----- rtl/lslf_mac.sv -----
// Shared multiplier with a registered product and a wide accumulator behind it.
module lslf_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lslf_pkg::mac_cmd_t                  cmd,
    input  logic signed [lslf_pkg::MUL_W-1:0]   mul_a,
    input  logic signed [lslf_pkg::MUL_W-1:0]   mul_b,
    output lslf_pkg::mac_sum_t                  prod_sum,
    output logic signed [lslf_pkg::ACC_W-1:0]   prod,
    output logic signed [lslf_pkg::ACC_W-1:0]   acc
);

    lslf_pkg::mac_cmd_t                 cmd_reg;
    lslf_pkg::mac_cmd_t                 cmd_next;
    logic signed [lslf_pkg::ACC_W-1:0]  prod_reg;
    logic signed [lslf_pkg::ACC_W-1:0]  prod_next;
    logic signed [lslf_pkg::ACC_W-1:0]  acc_reg;
    logic signed [lslf_pkg::ACC_W-1:0]  acc_next;
    logic signed [lslf_pkg::ACC_W-1:0]  addend;

    // Multiply stage: keep the low word of the product
    assign cmd_next  = cmd;
    assign prod_next = lslf_pkg::ACC_W'(mul_a * mul_b);

    // Accumulate stage: place the product and add, subtract or load it
    assign addend = cmd_reg.shift ? (prod_reg <<< lslf_pkg::ACC_SPLIT) : prod_reg;

    always_comb
    begin
        case (cmd_reg.op)
            lslf_pkg::ACC_LOAD: acc_next = addend;
            lslf_pkg::ACC_ADD:  acc_next = acc_reg + addend;
            lslf_pkg::ACC_SUB:  acc_next = acc_reg - addend;
            default:            acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= '{sum: lslf_pkg::SUM_NONE, op: lslf_pkg::ACC_NONE, shift: 1'b0};
        end
        else
        begin
            cmd_reg <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign prod_sum = cmd_reg.sum;
    assign prod     = prod_reg;
    assign acc      = acc_reg;

endmodule

// ----- rtl/lslf_div.sv -----
// Restoring divider, one quotient bit per cycle, low quotient word plus overflow flag.
module lslf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  lslf_pkg::div_req_t req,
    output lslf_pkg::div_rsp_t rsp
);

    logic                               busy_reg;
    logic                               busy_next;
    logic                               done_reg;
    logic                               done_next;
    logic [lslf_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [lslf_pkg::DIV_CNT_W-1:0]     cnt_next;
    logic [lslf_pkg::DVD_W-1:0]         dvd_reg;
    logic [lslf_pkg::DVD_W-1:0]         dvd_next;
    logic [lslf_pkg::DEN_W-1:0]         dsr_reg;
    logic [lslf_pkg::DEN_W-1:0]         dsr_next;
    logic [lslf_pkg::DEN_W-1:0]         rem_reg;
    logic [lslf_pkg::DEN_W-1:0]         rem_next;
    logic [lslf_pkg::Q_W-1:0]           q_reg;
    logic [lslf_pkg::Q_W-1:0]           q_next;
    logic                               high_reg;
    logic                               high_next;
    logic [lslf_pkg::DEN_W:0]           rem_sh;
    logic [lslf_pkg::DEN_W:0]           rem_diff;
    logic                               fits;

    // Trial subtract of the divisor from the shifted remainder
    assign rem_sh   = {rem_reg, dvd_reg[lslf_pkg::DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, dsr_reg};
    assign fits     = rem_sh >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        high_next = high_reg;
        if (req.start)
        begin
            // Load operands and clear the partial results
            busy_next = 1'b1;
            cnt_next  = lslf_pkg::DIV_CNT_W'(lslf_pkg::DVD_W);
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            q_next    = '0;
            high_next = 1'b0;
        end
        else if (busy_reg)
        begin
            // Retire one dividend bit; quotient bits above the word go sticky
            rem_next  = fits ? rem_diff[lslf_pkg::DEN_W-1:0] : rem_sh[lslf_pkg::DEN_W-1:0];
            dvd_next  = dvd_reg << 1;
            q_next    = {q_reg[lslf_pkg::Q_W-2:0], fits};
            high_next = high_reg | q_reg[lslf_pkg::Q_W-1];
            cnt_next  = cnt_reg - lslf_pkg::DIV_CNT_W'(1);
            if (cnt_reg == lslf_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        high_reg <= high_next;
    end

    assign rsp = '{done: done_reg, quotient: q_reg, q_high: high_reg};

endmodule

// ----- rtl/least_squares_line_fit.sv -----
// Top level of the least-squares line fit: sequencer, running sums and result register.
//
//   channel   dir  handshake          payload
//   point     in   valid / ready      x_sample, y_sample (Q7.8), last_sample
//   fit       out  valid / ready      slope, intercept (Q15.16), fit_status
//   cfg       in   cfg_wr_en          cfg_wr_data (denominator minimum)
//
// A point that is not the last passes S_IDLE and S_SQ (x*y, then x*x on the shared
// multiplier). A last point drains the sums in S_WAIT, forms denominator and numerator,
// divides for the slope, forms the intercept dividend, divides again and hands over in
// S_DONE; a degenerate set skips there after the numerator, an oversized set after S_WAIT.
// Reset clears the set and sets the denominator minimum to 1. A stalled result waits in
// the output register; points keep flowing until the next fit is ready.
module least_squares_line_fit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lslf_pkg::DMIN_W-1:0]     cfg_wr_data,
    lslf_point_if.sink                      point,
    lslf_fit_if.source                      fit
);

    typedef enum logic [17:0] {
        S_IDLE      = 18'h00001,
        S_SQ        = 18'h00002,
        S_WAIT      = 18'h00004,
        S_DEN_LO    = 18'h00008,
        S_DEN_HI    = 18'h00010,
        S_DEN_SX    = 18'h00020,
        S_NUM_LO    = 18'h00040,
        S_NUM_HI    = 18'h00080,
        S_NUM_SXY   = 18'h00100,
        S_NUM_W1    = 18'h00200,
        S_NUM_W2    = 18'h00400,
        S_SLOPE_DIV = 18'h00800,
        S_ICPT_SY   = 18'h01000,
        S_ICPT_SX   = 18'h02000,
        S_ICPT_W1   = 18'h04000,
        S_ICPT_W2   = 18'h08000,
        S_ICPT_DIV  = 18'h10000,
        S_DONE      = 18'h20000
    } state_t;

    state_t                                     state_reg;
    state_t                                     state_next;
    logic [lslf_pkg::CNT_W-1:0]                 count_reg;
    logic [lslf_pkg::CNT_W-1:0]                 count_next;
    logic signed [lslf_pkg::SUM_W-1:0]          sum_x_reg;
    logic signed [lslf_pkg::SUM_W-1:0]          sum_x_next;
    logic signed [lslf_pkg::SUM_W-1:0]          sum_y_reg;
    logic signed [lslf_pkg::SUM_W-1:0]          sum_y_next;
    logic signed [lslf_pkg::SXY_W-1:0]          sum_xy_reg;
    logic signed [lslf_pkg::SXY_W-1:0]          sum_xy_next;
    logic [lslf_pkg::SXX_W-1:0]                 sum_xx_reg;
    logic [lslf_pkg::SXX_W-1:0]                 sum_xx_next;
    logic                                       ovf_reg;
    logic                                       ovf_next;
    logic                                       took_reg;
    logic                                       took_next;
    logic                                       last_reg;
    logic                                       last_next;
    logic signed [lslf_pkg::SAMPLE_BITS-1:0]    x_reg;
    logic signed [lslf_pkg::SAMPLE_BITS-1:0]    x_next;
    logic [lslf_pkg::DEN_W-1:0]                 den_reg;
    logic [lslf_pkg::DEN_W-1:0]                 den_next;
    logic                                       sign_reg;
    logic                                       sign_next;
    logic signed [lslf_pkg::Q_W-1:0]            slope_reg;
    logic signed [lslf_pkg::Q_W-1:0]            slope_next;
    logic signed [lslf_pkg::Q_W-1:0]            icpt_reg;
    logic signed [lslf_pkg::Q_W-1:0]            icpt_next;
    lslf_pkg::fit_status_t                      status_reg;
    lslf_pkg::fit_status_t                      status_next;
    logic [lslf_pkg::DMIN_W-1:0]                dmin_reg;
    logic [lslf_pkg::DMIN_W-1:0]                dmin_next;
    logic                                       out_valid_reg;
    logic                                       out_valid_next;
    logic signed [lslf_pkg::Q_W-1:0]            out_slope_reg;
    logic signed [lslf_pkg::Q_W-1:0]            out_slope_next;
    logic signed [lslf_pkg::Q_W-1:0]            out_icpt_reg;
    logic signed [lslf_pkg::Q_W-1:0]            out_icpt_next;
    lslf_pkg::fit_status_t                      out_status_reg;
    lslf_pkg::fit_status_t                      out_status_next;

    logic signed [lslf_pkg::SAMPLE_BITS-1:0]    x_in;
    logic signed [lslf_pkg::SAMPLE_BITS-1:0]    y_in;
    logic                                       full;
    logic                                       out_load;
    logic                                       degenerate;
    logic                                       q_sat;
    logic                                       icpt_sat;
    logic [lslf_pkg::ACC_W-1:0]                 acc_mag;
    lslf_pkg::mac_cmd_t                         mac_cmd;
    logic signed [lslf_pkg::MUL_W-1:0]          mul_a;
    logic signed [lslf_pkg::MUL_W-1:0]          mul_b;
    lslf_pkg::mac_sum_t                         prod_sum;
    logic signed [lslf_pkg::ACC_W-1:0]          prod;
    logic signed [lslf_pkg::ACC_W-1:0]          acc;
    lslf_pkg::div_req_t                         div_req;
    lslf_pkg::div_rsp_t                         div_rsp;

    lslf_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (mac_cmd),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_sum (prod_sum),
        .prod     (prod),
        .acc      (acc)
    );

    lslf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Take the low sample bits as two's complement
    assign x_in = $signed(point.x_sample[lslf_pkg::SAMPLE_BITS-1:0]);
    assign y_in = $signed(point.y_sample[lslf_pkg::SAMPLE_BITS-1:0]);

    assign full       = count_reg >= lslf_pkg::CNT_W'(lslf_pkg::MAX_SAMPLES);
    assign degenerate = (den_reg == '0) || (den_reg < lslf_pkg::DEN_W'(dmin_reg));
    assign acc_mag    = acc[lslf_pkg::ACC_W-1] ? lslf_pkg::ACC_W'(-acc)
                                               : lslf_pkg::ACC_W'(acc);

    // Saturation of the slope and intercept quotients
    assign q_sat    = div_rsp.q_high | div_rsp.quotient[lslf_pkg::Q_W-1];
    assign icpt_sat = div_rsp.q_high | (div_rsp.quotient[lslf_pkg::Q_W-1] &
                      (!sign_reg | (div_rsp.quotient[lslf_pkg::Q_W-2:0] != '0)));

    assign point.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        sum_x_next      = sum_x_reg;
        sum_y_next      = sum_y_reg;
        sum_xy_next     = sum_xy_reg;
        sum_xx_next     = sum_xx_reg;
        ovf_next        = ovf_reg;
        took_next       = took_reg;
        last_next       = last_reg;
        x_next          = x_reg;
        den_next        = den_reg;
        sign_next       = sign_reg;
        slope_next      = slope_reg;
        icpt_next       = icpt_reg;
        status_next     = status_reg;
        out_load        = 1'b0;
        mac_cmd         = '{sum: lslf_pkg::SUM_NONE, op: lslf_pkg::ACC_NONE, shift: 1'b0};
        mul_a           = '0;
        mul_b           = '0;
        div_req         = '{start: 1'b0, dividend: '0, divisor: '0};

        // Fold finished products into the running sums
        if (prod_sum == lslf_pkg::SUM_XY)
        begin
            sum_xy_next = sum_xy_reg + lslf_pkg::SXY_W'(prod);
        end
        if (prod_sum == lslf_pkg::SUM_XX)
        begin
            sum_xx_next = sum_xx_reg + lslf_pkg::SXX_W'(prod);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                mul_a = lslf_pkg::MUL_W'(x_in);
                mul_b = lslf_pkg::MUL_W'(y_in);
                if (point.valid)
                begin
                    x_next    = x_in;
                    last_next = point.last_sample;
                    if (full)
                    begin
                        // Drop the point and flag the set
                        ovf_next  = 1'b1;
                        took_next = 1'b0;
                    end
                    else
                    begin
                        took_next   = 1'b1;
                        count_next  = count_reg + lslf_pkg::CNT_W'(1);
                        sum_x_next  = sum_x_reg + lslf_pkg::SUM_W'(x_in);
                        sum_y_next  = sum_y_reg + lslf_pkg::SUM_W'(y_in);
                        mac_cmd.sum = lslf_pkg::SUM_XY;
                    end
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                mul_a = lslf_pkg::MUL_W'(x_reg);
                mul_b = lslf_pkg::MUL_W'(x_reg);
                if (took_reg)
                begin
                    mac_cmd.sum = lslf_pkg::SUM_XX;
                end
                state_next = last_reg ? S_WAIT : S_IDLE;
            end
            S_WAIT:
            begin
                // Last product lands in the sums this cycle
                if (ovf_reg)
                begin
                    status_next = lslf_pkg::FIT_OVERFLOW;
                    slope_next  = '0;
                    icpt_next   = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_DEN_LO;
                end
            end
            S_DEN_LO:
            begin
                mul_a      = $signed(lslf_pkg::MUL_W'(count_reg));
                mul_b      = $signed(lslf_pkg::MUL_W'(sum_xx_reg[lslf_pkg::ACC_SPLIT-1:0]));
                mac_cmd.op = lslf_pkg::ACC_LOAD;
                state_next = S_DEN_HI;
            end
            S_DEN_HI:
            begin
                mul_a = $signed(lslf_pkg::MUL_W'(count_reg));
                mul_b = $signed(lslf_pkg::MUL_W'(
                            sum_xx_reg[lslf_pkg::SXX_W-1:lslf_pkg::ACC_SPLIT]));
                mac_cmd.op    = lslf_pkg::ACC_ADD;
                mac_cmd.shift = 1'b1;
                state_next    = S_DEN_SX;
            end
            S_DEN_SX:
            begin
                mul_a      = lslf_pkg::MUL_W'(sum_x_reg);
                mul_b      = lslf_pkg::MUL_W'(sum_x_reg);
                mac_cmd.op = lslf_pkg::ACC_SUB;
                state_next = S_NUM_LO;
            end
            S_NUM_LO:
            begin
                mul_a      = $signed(lslf_pkg::MUL_W'(count_reg));
                mul_b      = $signed(lslf_pkg::MUL_W'(sum_xy_reg[lslf_pkg::ACC_SPLIT-1:0]));
                mac_cmd.op = lslf_pkg::ACC_LOAD;
                state_next = S_NUM_HI;
            end
            S_NUM_HI:
            begin
                // Denominator is complete in the accumulator now
                den_next = acc[lslf_pkg::DEN_W-1:0];
                mul_a    = $signed(lslf_pkg::MUL_W'(count_reg));
                mul_b    = lslf_pkg::MUL_W'($signed(
                               sum_xy_reg[lslf_pkg::SXY_W-1:lslf_pkg::ACC_SPLIT]));
                mac_cmd.op    = lslf_pkg::ACC_ADD;
                mac_cmd.shift = 1'b1;
                state_next    = S_NUM_SXY;
            end
            S_NUM_SXY:
            begin
                mul_a      = lslf_pkg::MUL_W'(sum_x_reg);
                mul_b      = lslf_pkg::MUL_W'(sum_y_reg);
                mac_cmd.op = lslf_pkg::ACC_SUB;
                state_next = S_NUM_W1;
            end
            S_NUM_W1:
            begin
                if (degenerate)
                begin
                    status_next = lslf_pkg::FIT_DEGENERATE;
                    slope_next  = '0;
                    icpt_next   = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_NUM_W2;
                end
            end
            S_NUM_W2:
            begin
                // Divide |num| * 2^16 by the denominator
                sign_next        = acc[lslf_pkg::ACC_W-1];
                div_req.start    = 1'b1;
                div_req.dividend = lslf_pkg::DVD_W'({acc_mag[lslf_pkg::DEN_W-1:0],
                                                     {lslf_pkg::FRAC_W{1'b0}}});
                div_req.divisor  = den_reg;
                state_next       = S_SLOPE_DIV;
            end
            S_SLOPE_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (q_sat)
                    begin
                        slope_next = sign_reg ? lslf_pkg::Q_MIN : lslf_pkg::Q_MAX;
                    end
                    else
                    begin
                        slope_next = sign_reg ? -$signed(div_rsp.quotient)
                                              : $signed(div_rsp.quotient);
                    end
                    state_next = S_ICPT_SY;
                end
            end
            S_ICPT_SY:
            begin
                mul_a      = lslf_pkg::MUL_W'(sum_y_reg);
                mul_b      = lslf_pkg::Q16_ONE;
                mac_cmd.op = lslf_pkg::ACC_LOAD;
                state_next = S_ICPT_SX;
            end
            S_ICPT_SX:
            begin
                mul_a      = lslf_pkg::MUL_W'(slope_reg);
                mul_b      = lslf_pkg::MUL_W'(sum_x_reg);
                mac_cmd.op = lslf_pkg::ACC_SUB;
                state_next = S_ICPT_W1;
            end
            S_ICPT_W1:
            begin
                state_next = S_ICPT_W2;
            end
            S_ICPT_W2:
            begin
                // Divide |Sy*2^16 - slope*Sx| by n*256
                sign_next        = acc[lslf_pkg::ACC_W-1];
                div_req.start    = 1'b1;
                div_req.dividend = lslf_pkg::DVD_W'(acc_mag);
                div_req.divisor  = lslf_pkg::DEN_W'({count_reg, {lslf_pkg::INT_SHIFT{1'b0}}});
                state_next       = S_ICPT_DIV;
            end
            S_ICPT_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (icpt_sat)
                    begin
                        icpt_next = sign_reg ? lslf_pkg::Q_MIN : lslf_pkg::Q_MAX;
                    end
                    else
                    begin
                        icpt_next = sign_reg ? -$signed(div_rsp.quotient)
                                             : $signed(div_rsp.quotient);
                    end
                    status_next = lslf_pkg::FIT_OK;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hand the fit over once the output register is free, then clear the set
                if (!out_valid_reg || fit.ready)
                begin
                    out_load    = 1'b1;
                    count_next  = '0;
                    sum_x_next  = '0;
                    sum_y_next  = '0;
                    sum_xy_next = '0;
                    sum_xx_next = '0;
                    ovf_next    = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register and configuration
    assign out_valid_next  = out_load ? 1'b1 : (fit.ready ? 1'b0 : out_valid_reg);
    assign out_slope_next  = out_load ? slope_reg : out_slope_reg;
    assign out_icpt_next   = out_load ? icpt_reg : out_icpt_reg;
    assign out_status_next = out_load ? status_reg : out_status_reg;
    assign dmin_next       = cfg_wr_en ? cfg_wr_data : dmin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_xy_reg    <= '0;
            sum_xx_reg    <= '0;
            ovf_reg       <= 1'b0;
            took_reg      <= 1'b0;
            last_reg      <= 1'b0;
            dmin_reg      <= lslf_pkg::DMIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sum_xy_reg    <= sum_xy_next;
            sum_xx_reg    <= sum_xx_next;
            ovf_reg       <= ovf_next;
            took_reg      <= took_next;
            last_reg      <= last_next;
            dmin_reg      <= dmin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        den_reg        <= den_next;
        sign_reg       <= sign_next;
        slope_reg      <= slope_next;
        icpt_reg       <= icpt_next;
        status_reg     <= status_next;
        out_slope_reg  <= out_slope_next;
        out_icpt_reg   <= out_icpt_next;
        out_status_reg <= out_status_next;
    end

    assign fit.valid      = out_valid_reg;
    assign fit.slope      = out_slope_reg;
    assign fit.intercept  = out_icpt_reg;
    assign fit.fit_status = out_status_reg;

endmodule
